// ===== hdl/sai_pkg.sv =====
// Shared types and constants for the sorted key list.
`default_nettype none

package sai_pkg;

    // Fixed field widths of the word ports
    localparam int unsigned KEY_PORT_W = 32;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned ACT_W      = 2;
    localparam int unsigned STAT_W     = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_WALK,
        S_INS_PUT,
        S_RD_WAIT,
        S_RM_SHIFT
    } state_t;

    // Position pointer update
    typedef enum logic [2:0] {
        P_HOLD,
        P_HELD,
        P_INDEX,
        P_DEC,
        P_INC
    } p_sel_t;

    // Read address source
    typedef enum logic [2:0] {
        RD_HELD_M1,
        RD_INDEX,
        RD_P_M2,
        RD_P_P1,
        RD_P_P2
    } rd_sel_t;

    typedef enum logic {
        WR_DATA,
        WR_KEY
    } wr_sel_t;

    typedef enum logic [1:0] {
        HELD_KEEP,
        HELD_INC,
        HELD_DEC,
        HELD_CLR
    } held_op_t;

    typedef enum logic [1:0] {
        RK_ZERO,
        RK_RDATA,
        RK_SAVED
    } rk_sel_t;

    typedef struct packed {
        logic     load;
        p_sel_t   p_sel;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     cap_rk;
        logic     finish;
        held_op_t held_op;
        status_t  fin_status;
        rk_sel_t  rk_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic range_err;
        logic held_zero;
        logic ge;
        logic p_is_one;
        logic p1_lt_held;
        logic p2_lt_held;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sai_dp.sv =====
// Datapath of the sorted key list: key store, pointers, count and result registers.
`default_nettype none

module sai_dp
    import sai_pkg::*;
#(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [KEY_PORT_W-1:0] key,
    input  wire logic [IDX_W-1:0]      index,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    output logic                       done,
    output logic [KEY_PORT_W-1:0]      read_key,
    output logic [CNT_W-1:0]           count,
    output logic [STAT_W-1:0]          status
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    logic [CNT_W-1:0]     capacity_reg;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     p_reg, p_next;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] rk_reg;
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic                 done_reg;
    logic [KEY_WIDTH-1:0] read_key_reg, read_key_next;
    logic [CNT_W-1:0]     count_reg;
    status_t              status_reg;

    logic [CNT_W-1:0]     idx_ext;
    logic [CNT_W-1:0]     p_m1, p_p1, p_m2, p_p2, held_m1;
    logic [CNT_W:0]       p_p1_wide, p_p2_wide;
    logic [CNT_W-1:0]     rd_cnt;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;

    assign idx_ext   = {1'b0, index};
    assign p_m1      = p_reg - CNT_W'(1);
    assign p_m2      = p_reg - CNT_W'(2);
    assign p_p1      = p_reg + CNT_W'(1);
    assign p_p2      = p_reg + CNT_W'(2);
    assign held_m1   = held_reg - CNT_W'(1);
    assign p_p1_wide = {1'b0, p_reg} + (CNT_W+1)'(1);
    assign p_p2_wide = {1'b0, p_reg} + (CNT_W+1)'(2);

    // Status back to the controller
    always_comb
    begin
        stat.full       = (held_reg >= capacity_reg) || (32'(held_reg) >= 32'(DEPTH));
        stat.range_err  = (idx_ext >= held_reg);
        stat.held_zero  = (held_reg == '0);
        stat.ge         = (rd_data_reg >= key_reg);
        stat.p_is_one   = (p_reg == CNT_W'(1));
        stat.p1_lt_held = (p_p1_wide < {1'b0, held_reg});
        stat.p2_lt_held = (p_p2_wide < {1'b0, held_reg});
    end

    // Select read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_HELD_M1: rd_cnt = held_m1;
            RD_INDEX:   rd_cnt = idx_ext;
            RD_P_M2:    rd_cnt = p_m2;
            RD_P_P1:    rd_cnt = p_p1;
            RD_P_P2:    rd_cnt = p_p2;
            default:    rd_cnt = p_reg;
        endcase
    end

    assign rd_addr = AW'(rd_cnt);
    assign wr_addr = AW'(p_reg);
    assign wr_data = (cmd.wr_sel == WR_KEY) ? key_reg : rd_data_reg;

    // Key store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Select the next position pointer: hold, load or step it
    always_comb
    begin
        case (cmd.p_sel)
            P_HOLD:  p_next = p_reg;
            P_HELD:  p_next = held_reg;
            P_INDEX: p_next = idx_ext;
            P_DEC:   p_next = p_m1;
            P_INC:   p_next = p_p1;
            default: p_next = p_reg;
        endcase
    end

    // Update the key count on finish
    always_comb
    begin
        held_next = held_reg;
        if (cmd.finish)
        begin
            case (cmd.held_op)
                HELD_KEEP: held_next = held_reg;
                HELD_INC:  held_next = held_reg + CNT_W'(1);
                HELD_DEC:  held_next = held_m1;
                HELD_CLR:  held_next = '0;
                default:   held_next = held_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.rk_sel)
            RK_ZERO:  read_key_next = '0;
            RK_RDATA: read_key_next = rd_data_reg;
            RK_SAVED: read_key_next = rk_reg;
            default:  read_key_next = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            held_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            held_reg <= held_next;
            done_reg <= cmd.finish;
        end
    end

    // Hold operands and result word
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        if (cmd.load)
        begin
            key_reg <= KEY_WIDTH'(key);
        end
        if (cmd.cap_rk)
        begin
            rk_reg <= rd_data_reg;
        end
        if (cmd.finish)
        begin
            read_key_reg <= read_key_next;
            count_reg    <= held_next;
            status_reg   <= cmd.fin_status;
        end
    end

    assign done     = done_reg;
    assign read_key = KEY_PORT_W'(read_key_reg);
    assign count    = count_reg;
    assign status   = status_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (count_reg == held_reg))
        else $error("reported count differs from stored count");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(held_reg) <= 32'(DEPTH))
        else $error("stored count exceeds store depth");

    a_read_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (rd_cnt < held_reg))
        else $error("read outside the held keys");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (p_reg <= held_reg) && (32'(p_reg) < 32'(DEPTH)))
        else $error("write beyond the list end");

    a_no_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && (cmd.held_op == HELD_INC)) |-> !stat.full)
        else $error("insert completed on a full list");

endmodule

`default_nettype wire

// ===== hdl/sai_ctrl.sv =====
// Controller state machine of the sorted key list.
`default_nettype none

module sai_ctrl
    import sai_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [ACT_W-1:0] action,
    input  wire dp_stat_t         stat,
    output logic                  busy,
    output dp_cmd_t               cmd
);

    state_t  state_reg, state_next;
    logic    rm_reg, rm_next;
    action_t act;
    logic    accept;

    assign act    = action_t'(action);
    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign rm_next = accept ? (act == ACT_REMOVE) : rm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rm_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rm_reg    <= rm_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (act)
                        ACT_INSERT:
                        begin
                            if (!stat.full)
                            begin
                                state_next = stat.held_zero ? S_INS_PUT : S_INS_WALK;
                            end
                        end
                        ACT_LOOKUP, ACT_REMOVE:
                        begin
                            if (!stat.range_err)
                            begin
                                state_next = S_RD_WAIT;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_WALK:
            begin
                if (!stat.ge)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.p_is_one)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                state_next = S_IDLE;
            end
            S_RD_WAIT:
            begin
                state_next = (rm_reg && stat.p1_lt_held) ? S_RM_SHIFT : S_IDLE;
            end
            S_RM_SHIFT:
            begin
                if (!stat.p2_lt_held)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.p_sel      = P_HOLD;
        cmd.rd_sel     = RD_INDEX;
        cmd.wr_sel     = WR_DATA;
        cmd.held_op    = HELD_KEEP;
        cmd.fin_status = ST_OK;
        cmd.rk_sel     = RK_ZERO;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (act)
                        ACT_INSERT:
                        begin
                            if (stat.full)
                            begin
                                cmd.finish     = 1'b1;
                                cmd.fin_status = ST_FULL;
                            end
                            else
                            begin
                                // walk down from the top of the list
                                cmd.p_sel  = P_HELD;
                                cmd.rd_en  = !stat.held_zero;
                                cmd.rd_sel = RD_HELD_M1;
                            end
                        end
                        ACT_LOOKUP, ACT_REMOVE:
                        begin
                            if (stat.range_err)
                            begin
                                cmd.finish     = 1'b1;
                                cmd.fin_status = ST_RANGE;
                            end
                            else
                            begin
                                cmd.p_sel  = P_INDEX;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_INDEX;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cmd.finish  = 1'b1;
                            cmd.held_op = HELD_CLR;
                        end
                        default: cmd.load = 1'b1;
                    endcase
                end
            end
            S_INS_WALK:
            begin
                cmd.wr_en = 1'b1;
                if (stat.ge)
                begin
                    // shift a key not smaller than the new one up and look one lower
                    cmd.wr_sel = WR_DATA;
                    cmd.p_sel  = P_DEC;
                    cmd.rd_en  = !stat.p_is_one;
                    cmd.rd_sel = RD_P_M2;
                end
                else
                begin
                    cmd.wr_sel  = WR_KEY;
                    cmd.finish  = 1'b1;
                    cmd.held_op = HELD_INC;
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_KEY;
                cmd.finish  = 1'b1;
                cmd.held_op = HELD_INC;
            end
            S_RD_WAIT:
            begin
                if (!rm_reg)
                begin
                    cmd.finish = 1'b1;
                    cmd.rk_sel = RK_RDATA;
                end
                else if (stat.p1_lt_held)
                begin
                    // save the removed key and fetch its successor
                    cmd.cap_rk = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_P_P1;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    cmd.rk_sel  = RK_RDATA;
                    cmd.held_op = HELD_DEC;
                end
            end
            S_RM_SHIFT:
            begin
                // close the gap one entry per cycle
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_DATA;
                cmd.p_sel  = P_INC;
                if (stat.p2_lt_held)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_P_P2;
                end
                else
                begin
                    cmd.finish  = 1'b1;
                    cmd.rk_sel  = RK_SAVED;
                    cmd.held_op = HELD_DEC;
                end
            end
            default: cmd.load = 1'b0;
        endcase
    end

    a_one_finish_per_word: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && busy) |=> !busy)
        else $error("controller stayed busy after finishing a word");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en || cmd.wr_en || cmd.finish) |-> (busy || start))
        else $error("datapath command without a word in flight");

    a_walk_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_WALK) |-> $past(cmd.rd_en))
        else $error("insert walk without a pending read");

endmodule

`default_nettype wire

// ===== hdl/sorted_array_insert_remove_top.sv =====
// Top level of the sorted key list: controller and datapath.
//
//  channel   handshake          payload                      direction
//  command   start / busy       action, key, index           in
//  result    done (one cycle)   read_key, count, status      out
//  config    cfg_we             cfg_wdata (capacity)         in
//
// A word is taken at a clock edge with start high and busy low; done rises in
// the cycle after the word finishes. Full, out-of-range and clear words need no
// store access; an insert walks down from the top of the list and a remove
// shifts the keys above the index down; the walk moves one entry per cycle.
// Reset empties the list and sets capacity to 16; the store needs no sweep.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module sorted_array_insert_remove_top
    import sai_pkg::*;
#(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ACT_W-1:0]      action,
    input  wire logic [KEY_PORT_W-1:0] key,
    input  wire logic [IDX_W-1:0]      index,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    output logic                       done,
    output logic [KEY_PORT_W-1:0]      read_key,
    output logic [CNT_W-1:0]           count,
    output logic [STAT_W-1:0]          status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sai_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    sai_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .index     (index),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .read_key  (read_key),
        .count     (count),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== dv/sai_list_checker.sv =====
// Checker for the sorted key list: predicts every reply word and compares it with the block.
`default_nettype none

module sai_list_checker
    import sai_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic [ACT_W-1:0]      action,
    input  wire logic [KEY_PORT_W-1:0] key,
    input  wire logic [IDX_W-1:0]      index,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    input  wire logic                  done,
    input  wire logic [KEY_PORT_W-1:0] read_key,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [STAT_W-1:0]     status,
    output int                         replies_open,
    output int                         fail_count
);

    localparam int SLOTS = 16;

    typedef struct {
        logic [KEY_PORT_W-1:0] read_key;
        logic [CNT_W-1:0]      count;
        status_t               status;
    } reply_t;

    // Shadow copy of the list and its limit
    logic [KEY_PORT_W-1:0] list_keys [SLOTS];
    int                    list_held;
    logic [CNT_W-1:0]      list_cap;
    reply_t                pending_replies [$];

    // Apply one command word to the shadow list and return its reply
    function automatic reply_t apply_list_op(action_t op, logic [KEY_PORT_W-1:0] k,
                                             logic [IDX_W-1:0] idx);
        reply_t r;
        int     limit;
        int     pos;
        int     p;
        r.read_key = '0;
        r.status   = ST_OK;
        limit      = (int'(list_cap) > SLOTS) ? SLOTS : int'(list_cap);
        case (op)
            ACT_INSERT:
            begin
                if (list_held >= limit)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // insert ahead of the first key that is not less than the new one
                    pos = 0;
                    while (pos < list_held && list_keys[pos] < k)
                        pos++;
                    for (p = list_held; p > pos; p--)
                        list_keys[p] = list_keys[p-1];
                    list_keys[pos] = k;
                    list_held++;
                end
            end
            ACT_LOOKUP, ACT_REMOVE:
            begin
                if (int'(idx) >= list_held)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.read_key = list_keys[idx];
                    if (op == ACT_REMOVE)
                    begin
                        // close the gap
                        for (p = int'(idx); p + 1 < list_held; p++)
                            list_keys[p] = list_keys[p+1];
                        list_held--;
                    end
                end
            end
            default:
            begin
                list_held = 0;
            end
        endcase
        r.count = list_held[CNT_W-1:0];
        return r;
    endfunction

    // Retire replies, track the register, predict accepted words
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            list_held  = 0;
            list_cap   = CAP_RESET;
            fail_count = 0;
            pending_replies.delete();
            replies_open <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("reply word with no command waiting: read_key %0h count %0d status %0d",
                           read_key, count, status);
                    fail_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (read_key !== want.read_key)
                    begin
                        $error("read_key: expected %0h, actual %0h", want.read_key, read_key);
                        fail_count++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, count);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                list_cap = cfg_wdata;
            if (start && !busy)
                pending_replies.push_back(apply_list_op(action_t'(action), key, index));
            replies_open <= pending_replies.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/sorted_array_insert_remove_top_tb.sv =====
// Testbench top for the sorted key list: clock, reset, command stimulus and verdict.
`default_nettype none

module sorted_array_insert_remove_top_tb;
    import sai_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int PHASE_WORDS = 135;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [ACT_W-1:0]      action    = ACT_INSERT;
    logic [KEY_PORT_W-1:0] key       = '0;
    logic [IDX_W-1:0]      index     = '0;
    logic                  cfg_we    = 1'b0;
    logic [CNT_W-1:0]      cfg_wdata = '0;
    logic                  busy;
    logic                  done;
    logic [KEY_PORT_W-1:0] read_key;
    logic [CNT_W-1:0]      count;
    logic [STAT_W-1:0]     status;
    int                    replies_open;
    int                    fail_count;
    int                    cycles    = 0;
    bit                    no_gaps   = 1'b0;
    logic [CNT_W-1:0]      phase_caps [8];

    always #6 clk = ~clk;

    sorted_array_insert_remove_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .key       (key),
        .index     (index),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .read_key  (read_key),
        .count     (count),
        .status    (status)
    );

    sai_list_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .key          (key),
        .index        (index),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .read_key     (read_key),
        .count        (count),
        .status       (status),
        .replies_open (replies_open),
        .fail_count   (fail_count)
    );

    // Drive one command word and hold it until the block takes it
    task automatic issue(action_t op, logic [KEY_PORT_W-1:0] k, logic [IDX_W-1:0] idx);
        start  <= 1'b1;
        action <= op;
        key    <= k;
        index  <= idx;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Junk action shown on the bus while start is low
    function automatic action_t ACT_ACT_W_JUNK();
        return action_t'($urandom_range(0, 3));
    endfunction

    // Drop start for a random gap, about a third of the time
    task automatic maybe_idle();
        int n;
        if (!no_gaps && $urandom_range(0, 99) < 36)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            start  <= 1'b0;
            action <= ACT_ACT_W_JUNK();
            key    <= $urandom;
            index  <= IDX_W'($urandom_range(0, 15));
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every reply word has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (replies_open != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random word: insert-heavy so the list fills, keys often repeat
    task automatic random_word();
        int                    r;
        action_t               op;
        logic [KEY_PORT_W-1:0] k;
        logic [IDX_W-1:0]      idx;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = ACT_INSERT;
        else if (r < 70)
            op = ACT_LOOKUP;
        else if (r < 95)
            op = ACT_REMOVE;
        else
            op = ACT_CLEAR;
        case ($urandom_range(0, 9))
            0:       k = '0;
            1:       k = '1;
            2, 3, 4: k = $urandom_range(0, 7);
            default: k = $urandom;
        endcase
        if ($urandom_range(0, 1) == 1)
            idx = IDX_W'($urandom_range(0, 15));
        else
            idx = IDX_W'($urandom_range(0, 5));
        maybe_idle();
        issue(op, k, idx);
    endtask

    // Stimulus
    initial
    begin
        phase_caps[0] = 5'd16;
        phase_caps[1] = 5'd1;
        phase_caps[2] = 5'd0;
        phase_caps[3] = 5'd31;
        phase_caps[4] = 5'd3;
        phase_caps[5] = 5'd16;
        phase_caps[6] = CNT_W'($urandom_range(1, 16));
        phase_caps[7] = 5'd17;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, duplicates, extremes, clear
        issue(ACT_LOOKUP, '0, 4'd0);
        issue(ACT_REMOVE, '0, 4'd0);
        issue(ACT_INSERT, 32'hFFFF_FFFF, 4'd0);
        issue(ACT_INSERT, 32'h0000_0000, 4'd0);
        issue(ACT_INSERT, 32'd7, 4'd0);
        issue(ACT_INSERT, 32'd7, 4'd0);
        issue(ACT_LOOKUP, '0, 4'd0);
        issue(ACT_LOOKUP, '0, 4'd1);
        issue(ACT_LOOKUP, '0, 4'd2);
        issue(ACT_LOOKUP, '0, 4'd3);
        issue(ACT_LOOKUP, '0, 4'd15);
        issue(ACT_REMOVE, '0, 4'd3);
        issue(ACT_REMOVE, '0, 4'd1);
        issue(ACT_CLEAR, '1, 4'd15);
        issue(ACT_INSERT, 32'hAAAA_AAAA, 4'd0);
        issue(ACT_INSERT, 32'h5555_5555, 4'd0);
        issue(ACT_LOOKUP, '0, 4'd1);
        issue(ACT_INSERT, 32'd1, 4'd0);
        // shrink capacity below the held count, then to zero
        write_capacity(5'd2);
        issue(ACT_INSERT, 32'd9, 4'd0);
        issue(ACT_REMOVE, '0, 4'd0);
        issue(ACT_INSERT, 32'd9, 4'd0);
        issue(ACT_REMOVE, '0, 4'd0);
        issue(ACT_INSERT, 32'd9, 4'd0);
        write_capacity(5'd0);
        issue(ACT_INSERT, 32'd3, 4'd0);

        // random phases, each under its own capacity
        for (int ph = 0; ph < 8; ph++)
        begin
            write_capacity(phase_caps[ph]);
            no_gaps = (ph == 3);
            repeat (PHASE_WORDS) random_word();
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

`default_nettype wire
